// ===== hw/rtl/sra_pkg.sv =====
// Shared types and constants of the skyline rectangle allocator.
package sra_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 12;

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Area saturates at this value.
  localparam logic [24:0] AREA_MAX = 25'd16777216;

  // Request word.
  typedef struct packed {
    logic        opcode;
    logic [11:0] req_width;
    logic [11:0] req_height;
  } req_t;

  // Response word.
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] region_x;
    logic [11:0] region_y;
    logic [24:0] used_area;
  } rsp_t;

endpackage

// ===== hw/rtl/skyline_rect_allocator.sv =====
// A clear or a zero-width request goes straight from idle to the done state.
// An allocation reads one segment per read and process state pair: the fit scan reads every
// segment it walks, and the rebuild then reads each live segment again into the other bank.
// The skyline memory read is registered, hence the separate read and process states.
// One request is in work at a time; a finished word waits in the output register.
// Reset: the S_INIT state writes the initial segment, then requests are taken.
module skyline_rect_allocator #(
  parameter int MAX_SEGMENTS = sra_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = sra_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sra_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sra_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [12:0]   cfg_data
);
  import sra_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int EW   = ((CW > 12) ? CW : 12) + 2;
  localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
  } seg_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SRD, S_SPROC, S_BRD, S_BPROC, S_FLUSH, S_DONE
  } state_t;

  // Clamp an atlas dimension to the supported range.
  function automatic logic [CW:0] eff_dim(logic [12:0] v);
    logic [CW:0] r;
    if (v < 13'd3) begin
      r = (CW+1)'(3);
    end else if (32'(v) > (32'd1 << CW)) begin
      r = (CW+1)'(32'd1 << CW);
    end else begin
      r = (CW+1)'(v);
    end
    return r;
  endfunction

  // Two skyline banks: one is live, the other receives the rebuilt list.
  seg_t mem0 [MAX_SEGMENTS];
  seg_t mem1 [MAX_SEGMENTS];
  seg_t rdata;

  state_t          state;
  logic            bank;
  logic [CNTW-1:0] seg_count;
  logic [24:0]     area;
  logic [12:0]     atlas_w;
  logic [12:0]     atlas_h;
  logic [11:0]     w_q;
  logic [11:0]     h_q;
  logic [23:0]     prod;
  logic [CNTW-1:0] ptr;
  logic [CNTW-1:0] cur_i;
  logic            head;
  logic [CW-1:0]   yacc;
  logic [11:0]     left;
  logic [CW-1:0]   hw;
  logic [CW-1:0]   cur_x;
  logic            found;
  logic [EW-1:0]   best_top;
  logic [CW-1:0]   best_w;
  logic [CNTW-1:0] best_i;
  logic [CW-1:0]   best_y;
  logic [CW-1:0]   best_x;
  logic [CNTW-1:0] wptr;
  logic            pend_v;
  seg_t            pend;
  logic            ins_done;
  logic            trim;
  rsp_t            res;

  // Derived limits.
  logic [CW:0] eff_w;
  logic [CW:0] eff_h;
  logic [EW-1:0] wlim;
  logic [EW-1:0] hlim;
  seg_t clr_seg;

  assign eff_w   = eff_dim(atlas_w);
  assign eff_h   = eff_dim(atlas_h);
  assign wlim    = EW'(eff_w) - EW'(1);
  assign hlim    = EW'(eff_h) - EW'(1);
  assign clr_seg = '{x: CW'(1), y: CW'(1), w: CW'(eff_w - (CW+1)'(2))};

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // The output register takes a finished word when it is free or being drained.
  logic rsp_load;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // Fit walk step on the segment just read.
  logic [CW-1:0] y0, ymax, cand_w, cand_x;
  logic [11:0]   left_cur, left_nx;
  logic [EW-1:0] topv;
  logic xfail, hfail, done_w, ok_i, fail_i, better, last_i;

  always_comb begin
    y0       = head ? rdata.y : yacc;
    ymax     = (rdata.y > y0) ? rdata.y : y0;
    xfail    = head && ((EW'(rdata.x) + EW'(w_q)) > wlim);
    topv     = EW'(ymax) + EW'(h_q);
    hfail    = topv > hlim;
    left_cur = head ? w_q : left;
    done_w   = EW'(rdata.w) >= EW'(left_cur);
    left_nx  = 12'(EW'(left_cur) - EW'(rdata.w));
    cand_w   = head ? rdata.w : hw;
    cand_x   = head ? rdata.x : cur_x;
    ok_i     = !xfail && !hfail && done_w;
    fail_i   = xfail || hfail ||
               (!done_w && ((ptr + CNTW'(1)) >= seg_count));
    better   = !found || (topv < best_top) ||
               ((topv == best_top) && (cand_w < best_w));
    last_i   = (cur_i + CNTW'(1)) >= seg_count;
  end

  // Rebuild step: copy, insert, trim and merge into the other bank.
  seg_t          new_seg, eseg;
  logic [EW-1:0] pend_end, shrink;
  logic          emit, advance, trim_off, merge;

  always_comb begin
    new_seg  = '{x: best_x, y: best_top[CW-1:0], w: CW'(w_q)};
    pend_end = EW'(best_x) + EW'(w_q);
    shrink   = pend_end - EW'(rdata.x);
    eseg     = rdata;
    emit     = 1'b1;
    advance  = 1'b1;
    trim_off = 1'b0;
    if (ptr < best_i) begin
      eseg = rdata;
    end else if (!ins_done) begin
      eseg    = new_seg;
      advance = 1'b0;
    end else if (trim && (EW'(rdata.x) < pend_end)) begin
      if (EW'(rdata.w) <= shrink) begin
        emit = 1'b0;
      end else begin
        eseg.x   = CW'(EW'(rdata.x) + shrink);
        eseg.w   = CW'(EW'(rdata.w) - shrink);
        trim_off = 1'b1;
      end
    end else begin
      trim_off = 1'b1;
    end
    merge = pend_v && (pend.y == eseg.y);
  end

  // Memory write port.
  logic          we, wsel;
  logic [IW-1:0] waddr;
  seg_t          wdata;

  always_comb begin
    we    = 1'b0;
    wsel  = ~bank;
    waddr = wptr[IW-1:0];
    wdata = pend;
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wsel  = 1'b0;
        waddr = '0;
        wdata = clr_seg;
      end
      S_IDLE: begin
        we    = req_acc && (req.opcode == OP_CLEAR);
        waddr = '0;
        wdata = clr_seg;
      end
      S_BPROC: we = emit && pend_v && !merge;
      S_FLUSH: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      if (wsel) begin
        mem1[waddr] <= wdata;
      end else begin
        mem0[waddr] <= wdata;
      end
    end
    rdata <= bank ? mem1[ptr[IW-1:0]] : mem0[ptr[IW-1:0]];
    prod  <= w_q * h_q;
  end

  // Saturating area after this allocation.
  logic [25:0] area_sum;
  logic [24:0] area_n;
  assign area_sum = 26'(area) + 26'(prod);
  assign area_n   = (area_sum >= 26'(AREA_MAX)) ? AREA_MAX : area_sum[24:0];

  // Sequencer, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      bank      <= 1'b0;
      seg_count <= CNTW'(1);
      area      <= '0;
      atlas_w   <= 13'd512;
      atlas_h   <= 13'd512;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) begin
          atlas_w <= cfg_data;
        end else begin
          atlas_h <= cfg_data;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (req_acc) begin
            w_q <= req.req_width;
            h_q <= req.req_height;
            if (req.opcode == OP_CLEAR) begin
              bank      <= ~bank;
              seg_count <= CNTW'(1);
              area      <= '0;
              res       <= '{status: STAT_OK, region_x: '0, region_y: '0, used_area: '0};
              state     <= S_DONE;
            end else if (req.req_width == 12'd0) begin
              res   <= '{status: STAT_NO_ROOM, region_x: '0, region_y: '0, used_area: area};
              state <= S_DONE;
            end else begin
              cur_i <= '0;
              ptr   <= '0;
              head  <= 1'b1;
              found <= 1'b0;
              state <= S_SRD;
            end
          end
        end
        S_SRD: state <= S_SPROC;
        S_SPROC: begin
          if (head) begin
            hw    <= rdata.w;
            cur_x <= rdata.x;
          end
          if (ok_i || fail_i) begin
            if (ok_i && better) begin
              found    <= 1'b1;
              best_top <= topv;
              best_w   <= cand_w;
              best_i   <= cur_i;
              best_y   <= ymax;
              best_x   <= cand_x;
            end
            if (last_i) begin
              if (!(found || ok_i)) begin
                res   <= '{status: STAT_NO_ROOM, region_x: '0, region_y: '0,
                           used_area: area};
                state <= S_DONE;
              end else if (seg_count >= CNTW'(MAX_SEGMENTS)) begin
                res   <= '{status: STAT_FULL, region_x: '0, region_y: '0,
                           used_area: area};
                state <= S_DONE;
              end else begin
                ptr      <= '0;
                wptr     <= '0;
                pend_v   <= 1'b0;
                ins_done <= 1'b0;
                trim     <= 1'b0;
                state    <= S_BRD;
              end
            end else begin
              cur_i <= cur_i + CNTW'(1);
              ptr   <= cur_i + CNTW'(1);
              head  <= 1'b1;
              state <= S_SRD;
            end
          end else begin
            head  <= 1'b0;
            yacc  <= ymax;
            left  <= left_nx;
            ptr   <= ptr + CNTW'(1);
            state <= S_SRD;
          end
        end
        S_BRD: state <= S_BPROC;
        S_BPROC: begin
          if (emit) begin
            if (merge) begin
              pend.w <= pend.w + eseg.w;
            end else begin
              pend   <= eseg;
              pend_v <= 1'b1;
              if (pend_v) begin
                wptr <= wptr + CNTW'(1);
              end
            end
          end
          if (!advance) begin
            ins_done <= 1'b1;
            trim     <= 1'b1;
          end else begin
            if (trim_off) begin
              trim <= 1'b0;
            end
            if ((ptr + CNTW'(1)) >= seg_count) begin
              state <= S_FLUSH;
            end else begin
              ptr   <= ptr + CNTW'(1);
              state <= S_BRD;
            end
          end
        end
        S_FLUSH: begin
          seg_count <= wptr + CNTW'(1);
          bank      <= ~bank;
          area      <= area_n;
          res       <= '{status: STAT_OK, region_x: 12'(best_x), region_y: 12'(best_y),
                         used_area: area_n};
          state     <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The live segment count stays between one and the store size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (seg_count != '0) && (seg_count <= CNTW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // Rebuild writes stay inside the store.
  a_wptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BPROC && we) |-> (wptr < CNTW'(MAX_SEGMENTS)))
    else $error("rebuild write beyond store");

  // A clear leaves a single segment and an empty area count.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.opcode == OP_CLEAR) |=> (seg_count == CNTW'(1) && area == '0))
    else $error("clear did not reset the skyline");

  // Responses carry only defined status codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == STAT_OK || rsp.status == STAT_NO_ROOM ||
                   rsp.status == STAT_FULL))
    else $error("undefined response status");

endmodule
